// ===== rtl/tlw_pkg.sv =====
// Shared types and constants for the ticket lock with waiter wake-up.
package tlw_pkg;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 3;
  localparam int unsigned ISSUED_W    = 16;
  localparam int unsigned THREAD_W    = 8;

  typedef enum logic [1:0] {
    STATUS_GRANTED  = 2'd0,
    STATUS_QUEUED   = 2'd1,
    STATUS_RELEASED = 2'd2,
    STATUS_REJECTED = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef enum logic {
    ACTION_LOCK   = 1'b0,
    ACTION_UNLOCK = 1'b1
  } action_e;

  // broadcast to every waiter cell
  typedef struct packed {
    logic alloc;
    logic wake;
  } cell_cmd_t;

  // rippled from cell to cell, lowest index first
  typedef struct packed {
    logic free_seen;
    logic hit_seen;
  } chain_t;

endpackage

// ===== rtl/tlw_cell.sv =====
// One waiter slot: valid bit, thread and ticket, with its link in the priority chain.
module tlw_cell #(
  parameter int unsigned TICKET_BITS = 16,
  parameter int unsigned THREAD_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tlw_pkg::cell_cmd_t     cmd_i,
  input  logic [TICKET_BITS-1:0] key_i,
  input  logic [THREAD_BITS-1:0] thread_i,
  input  tlw_pkg::chain_t        chain_i,
  input  logic [THREAD_BITS-1:0] hit_thread_i,
  output tlw_pkg::chain_t        chain_o,
  output logic [THREAD_BITS-1:0] hit_thread_o
);

  logic                   valid_q, valid_d;
  logic [TICKET_BITS-1:0] ticket_q;
  logic [THREAD_BITS-1:0] thread_q;
  logic                   match;
  logic                   claim;
  logic                   hit;

  assign match = valid_q && (ticket_q == key_i);
  assign claim = cmd_i.alloc && !valid_q && !chain_i.free_seen;
  assign hit   = cmd_i.wake && match && !chain_i.hit_seen;

  assign chain_o.free_seen = chain_i.free_seen | !valid_q;
  assign chain_o.hit_seen  = chain_i.hit_seen | (cmd_i.wake & match);
  assign hit_thread_o      = hit ? thread_q : hit_thread_i;

  always_comb begin
    valid_d = valid_q;
    if (claim) begin
      valid_d = 1'b1;
    end else if (hit) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (claim) begin
      ticket_q <= key_i;
      thread_q <= thread_i;
    end
  end

endmodule

// ===== rtl/ticket_lock_with_waiter_wake_core.sv =====
// Ticket lock with waiter wake-up: top level, counters, control and output register.
//
// Requests enter on the s_axis channel: tuser is the action (0 lock, 1 unlock),
// tdata the requesting thread. Each request produces exactly one response on
// m_axis: tuser holds status and the wake flag, tdata the issued ticket and the
// woken thread.
// A lock draws the next ticket and is granted at once if that ticket is being
// served; otherwise the thread waits in a row of WAITER_SLOTS cells (lowest free
// cell first), or is rejected without a ticket when every cell is taken. An
// unlock with a ticket outstanding advances serving and wakes that ticket's cell.
// An accepted request is latched and executed in the BUSY state, which loads
// the response register; m_axis presents the response from that register.
// Only one request is in flight: none is taken while one executes in BUSY;
// the slot search and ticket match ripple through the cell row combinationally.
// Reset clears both counters and all cell valid bits; no clearing pass.
// A stalled response holds in the output register; a new request is taken only
// once that register is empty or being drained in the same cycle.
module ticket_lock_with_waiter_wake_core #(
  parameter int unsigned WAITER_SLOTS = 16,
  parameter int unsigned TICKET_BITS  = 16,
  parameter int unsigned THREAD_BITS  = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [tlw_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // [7:0] thread_id
  input  logic                               s_axis_tuser_i,  // [0] action
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [15:0] issued_ticket, [23:16] wake_thread
  output logic [tlw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // [1:0] status, [2] wake_valid
  output logic [tlw_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o
);

  tlw_pkg::state_e        state_q, state_d;
  logic                   req_action_q;
  logic [THREAD_BITS-1:0] req_thread_q;
  logic [TICKET_BITS-1:0] next_q, next_d;
  logic [TICKET_BITS-1:0] serving_q, serving_d;
  logic [TICKET_BITS-1:0] serving_inc;
  logic [TICKET_BITS-1:0] key;
  logic                   s_fire;
  logic                   is_lock;
  logic                   held;
  logic                   full;

  tlw_pkg::cell_cmd_t     cmd;
  tlw_pkg::chain_t        chain   [WAITER_SLOTS+1];
  logic [THREAD_BITS-1:0] hit_thr [WAITER_SLOTS+1];

  logic                   out_valid_q, out_valid_d;
  tlw_pkg::status_e       out_status_q, out_status_d;
  logic [tlw_pkg::ISSUED_W-1:0] out_issued_q, out_issued_d;
  logic                   out_wake_q, out_wake_d;
  logic [tlw_pkg::THREAD_W-1:0] out_thread_q, out_thread_d;
  logic [31:0]            next_wide;
  logic [15:0]            thr_wide;

  assign s_fire      = s_axis_tvalid_i && s_axis_tready_o;
  assign is_lock     = (req_action_q == tlw_pkg::ACTION_LOCK);
  assign held        = (next_q != serving_q);
  assign serving_inc = serving_q + TICKET_BITS'(1);
  assign key         = is_lock ? next_q : serving_inc;
  assign full        = !chain[WAITER_SLOTS].free_seen;
  assign next_wide   = 32'(next_q);
  assign thr_wide    = 16'(hit_thr[WAITER_SLOTS]);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tlw_pkg::ST_IDLE: if (s_fire) state_d = tlw_pkg::ST_BUSY;
      tlw_pkg::ST_BUSY: state_d = tlw_pkg::ST_IDLE;
      default:          state_d = tlw_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    cmd             = '0;
    case (state_q)
      tlw_pkg::ST_IDLE: s_axis_tready_o = !out_valid_q || m_axis_tready_i;
      tlw_pkg::ST_BUSY: begin
        cmd.alloc = is_lock && held;
        cmd.wake  = !is_lock && held;
      end
      default: ;
    endcase
  end

  assign chain[0]   = '0;
  assign hit_thr[0] = '0;

  for (genvar i = 0; i < WAITER_SLOTS; i++) begin : g_cell
    tlw_cell #(
      .TICKET_BITS(TICKET_BITS),
      .THREAD_BITS(THREAD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (key),
      .thread_i    (req_thread_q),
      .chain_i     (chain[i]),
      .hit_thread_i(hit_thr[i]),
      .chain_o     (chain[i+1]),
      .hit_thread_o(hit_thr[i+1])
    );
  end

  // execute: counters and response
  always_comb begin
    next_d       = next_q;
    serving_d    = serving_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_issued_d = out_issued_q;
    out_wake_d   = out_wake_q;
    out_thread_d = out_thread_q;
    if (state_q == tlw_pkg::ST_BUSY) begin
      out_valid_d  = 1'b1;
      out_issued_d = '0;
      out_wake_d   = 1'b0;
      out_thread_d = '0;
      if (is_lock) begin
        if (held && full) begin
          out_status_d = tlw_pkg::STATUS_REJECTED;
        end else begin
          out_status_d = held ? tlw_pkg::STATUS_QUEUED : tlw_pkg::STATUS_GRANTED;
          out_issued_d = next_wide[15:0];
          next_d       = next_q + TICKET_BITS'(1);
        end
      end else begin
        out_status_d = tlw_pkg::STATUS_RELEASED;
        if (held) begin
          serving_d    = serving_inc;
          out_wake_d   = chain[WAITER_SLOTS].hit_seen;
          out_thread_d = thr_wide[7:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlw_pkg::ST_IDLE;
      next_q      <= '0;
      serving_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      serving_q   <= serving_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_action_q <= s_axis_tuser_i;
      req_thread_q <= THREAD_BITS'(s_axis_tdata_i);
    end
    out_status_q <= out_status_d;
    out_issued_q <= out_issued_d;
    out_wake_q   <= out_wake_d;
    out_thread_q <= out_thread_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_thread_q, out_issued_q};
  assign m_axis_tuser_o  = {out_wake_q, out_status_q};

endmodule

// ===== rtl/tlw_checker.sv =====
// Port-level checker for the ticket lock core, bound to the top level.
module tlw_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [tlw_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [tlw_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  logic s_fire;
  logic m_stall;

  assign s_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign m_stall = m_axis_tvalid_o && !m_axis_tready_i;

  a_resp_two_cycles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> ##2 m_axis_tvalid_o)
    else $error("request without response two cycles later");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("request taken while previous one executes");

  a_wake_only_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[2]) |->
      (m_axis_tuser_o[1:0] == tlw_pkg::STATUS_RELEASED))
    else $error("wake reported on a lock response");

  a_reject_no_ticket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o[1:0] == tlw_pkg::STATUS_REJECTED)) |->
      (m_axis_tdata_o == '0))
    else $error("rejected lock carries a ticket");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_stall |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled response changed");

endmodule

bind ticket_lock_with_waiter_wake_core tlw_checker u_tlw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
